// ----- hw/rtl/nnis_pkg.sv -----
// Shared types, constants and register codes of the nearest-neighbor image scaler.
`default_nettype none

package nnis_pkg;

   localparam int MAX_SRC_WIDTH_DEFAULT  = 256;
   localparam int MAX_SRC_HEIGHT_DEFAULT = 256;
   localparam int PIXEL_BITS_DEFAULT     = 32;

   localparam int FRAC_BITS      = 16;
   localparam int STEP_BITS      = 24;
   localparam int COUNT_BITS     = 12;
   localparam int SRC_SIZE_BITS  = 9;
   localparam int COORD_BITS     = 8;
   localparam int PORT_PIX_BITS  = 32;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 12;
   localparam int SIZE_RESET     = 256;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SRC_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SRC_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DST_WIDTH  = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DST_HEIGHT = 2'd3;

   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_FETCH = 1'b1;

   typedef struct packed {
      logic store_write;
      logic frame_init;
      logic div_start;
      logic div_sel_y;
      logic step_x_load;
      logic step_y_load;
      logic read_en;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic frame_started;
      logic div_busy;
      logic out_blocked;
   } status_type;

endpackage

`default_nettype wire

// ----- hw/rtl/nnis_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module nnis_div #(
   parameter int DVD_BITS = 25,
   parameter int DVS_BITS = 12
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [DVD_BITS-1:0] dividend,
   input  wire logic [DVS_BITS-1:0] divisor,
   output logic                     busy,
   output logic [DVD_BITS-1:0]      quotient
);

   localparam int CNT_BITS = $clog2(DVD_BITS);

   logic                busy_ff, busy_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [DVD_BITS-1:0] dvd_ff, dvd_in;
   logic [DVS_BITS-1:0] rem_ff, rem_in;
   logic [DVS_BITS-1:0] divisor_ff, divisor_in;
   logic [DVS_BITS:0]   trial;
   logic                fits;

   always_comb begin
      trial      = {rem_ff, dvd_ff[DVD_BITS-1]};
      fits       = (trial >= {1'b0, divisor_ff});
      busy_in    = busy_ff;
      cnt_in     = cnt_ff;
      dvd_in     = dvd_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         cnt_in     = CNT_BITS'(DVD_BITS - 1);
         dvd_in     = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? DVS_BITS'(trial - {1'b0, divisor_ff}) : DVS_BITS'(trial);
         dvd_in = {dvd_ff[DVD_BITS-2:0], fits};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff     <= dvd_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign busy     = busy_ff;
   assign quotient = dvd_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/nnis_ctrl.sv -----
// Controller state machine that sequences writes, step divisions and pixel fetches.
`default_nettype none

module nnis_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_type,
   input  wire nnis_pkg::status_type status,
   output logic                     req_stall,
   output nnis_pkg::cmd_type        cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DIV_X = 3'd1;
   localparam logic [2:0] S_DIV_Y = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_LOAD  = 3'd4;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_type == nnis_pkg::REQ_WRITE) begin
                  cmd.store_write = 1'b1;
               end else if (status.frame_started) begin
                  state_in = S_READ;
               end else begin
                  cmd.frame_init = 1'b1;
                  cmd.div_start  = 1'b1;
                  state_in       = S_DIV_X;
               end
            end
         end
         S_DIV_X: begin
            if (!status.div_busy) begin
               cmd.step_x_load = 1'b1;
               cmd.div_start   = 1'b1;
               cmd.div_sel_y   = 1'b1;
               state_in        = S_DIV_Y;
            end
         end
         S_DIV_Y: begin
            if (!status.div_busy) begin
               cmd.step_y_load = 1'b1;
               state_in        = S_READ;
            end
         end
         S_READ: begin
            cmd.read_en = 1'b1;
            state_in    = S_LOAD;
         end
         S_LOAD: begin
            if (!status.out_blocked) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/nnis_datapath.sv -----
// Datapath with size registers, step divider, accumulators, frame store and output register.
`default_nettype none

module nnis_datapath #(
   parameter int MAX_SRC_WIDTH  = nnis_pkg::MAX_SRC_WIDTH_DEFAULT,
   parameter int MAX_SRC_HEIGHT = nnis_pkg::MAX_SRC_HEIGHT_DEFAULT,
   parameter int PIXEL_BITS     = nnis_pkg::PIXEL_BITS_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire nnis_pkg::cmd_type                    cmd,
   output nnis_pkg::status_type                      status,
   input  wire logic                                 csr_write_en,
   input  wire logic [nnis_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [nnis_pkg::CSR_DATA_BITS-1:0]   csr_write_data,
   input  wire logic [nnis_pkg::COORD_BITS-1:0]      req_src_col,
   input  wire logic [nnis_pkg::COORD_BITS-1:0]      req_src_row,
   input  wire logic [nnis_pkg::PORT_PIX_BITS-1:0]   req_pixel_in,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_valid,
   output logic [nnis_pkg::PORT_PIX_BITS-1:0]        rsp_pixel_out,
   output logic [nnis_pkg::COUNT_BITS-1:0]           rsp_out_col,
   output logic [nnis_pkg::COUNT_BITS-1:0]           rsp_out_row,
   output logic                                      rsp_frame_last
);

   localparam int SW_BITS    = $clog2(MAX_SRC_WIDTH + 1);
   localparam int SH_BITS    = $clog2(MAX_SRC_HEIGHT + 1);
   localparam int SZ_BITS    = (SW_BITS > SH_BITS) ? SW_BITS : SH_BITS;
   localparam int DVD_BITS   = SZ_BITS + nnis_pkg::FRAC_BITS;
   localparam int COL_BITS   = $clog2(MAX_SRC_WIDTH);
   localparam int ROW_BITS   = $clog2(MAX_SRC_HEIGHT);
   localparam int DEPTH      = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
   localparam int ADDR_BITS  = $clog2(DEPTH);
   localparam int CB         = nnis_pkg::COUNT_BITS;
   localparam int SB         = nnis_pkg::STEP_BITS;
   localparam int FB         = nnis_pkg::FRAC_BITS;

   logic [nnis_pkg::SRC_SIZE_BITS-1:0] src_width_ff, src_height_ff;
   logic [CB-1:0]                      dst_width_ff, dst_height_ff;
   logic [SB-1:0]                      step_x_ff, step_y_ff, acc_x_ff, acc_y_ff;
   logic [CB-1:0]                      col_count_ff, row_count_ff;
   logic                               frame_started_ff;
   logic [PIXEL_BITS-1:0]              mem [DEPTH];
   logic [PIXEL_BITS-1:0]              rd_data_ff;
   logic                               rsp_valid_ff;
   logic [nnis_pkg::PORT_PIX_BITS-1:0] rsp_pixel_out_ff;
   logic [CB-1:0]                      rsp_out_col_ff, rsp_out_row_ff;
   logic                               rsp_frame_last_ff;

   logic [SW_BITS-1:0]   sw;
   logic [SH_BITS-1:0]   sh;
   logic [CB-1:0]        dw, dh;
   logic [SZ_BITS-1:0]   div_size;
   logic [DVD_BITS-1:0]  div_dividend;
   logic [CB-1:0]        div_divisor;
   logic                 div_busy;
   logic [DVD_BITS-1:0]  div_quotient;
   logic [COL_BITS-1:0]  sc;
   logic [ROW_BITS-1:0]  sr;
   logic [ADDR_BITS-1:0] rd_addr, wr_addr;
   logic                 wr_in_range;
   logic                 row_end, frame_end;

   always_comb begin
      if (src_width_ff == '0) begin
         sw = SW_BITS'(1);
      end else if (32'(src_width_ff) > 32'(MAX_SRC_WIDTH)) begin
         sw = SW_BITS'(MAX_SRC_WIDTH);
      end else begin
         sw = SW_BITS'(src_width_ff);
      end
      if (src_height_ff == '0) begin
         sh = SH_BITS'(1);
      end else if (32'(src_height_ff) > 32'(MAX_SRC_HEIGHT)) begin
         sh = SH_BITS'(MAX_SRC_HEIGHT);
      end else begin
         sh = SH_BITS'(src_height_ff);
      end
      dw = (dst_width_ff == '0) ? CB'(1) : dst_width_ff;
      dh = (dst_height_ff == '0) ? CB'(1) : dst_height_ff;
   end

   // The dividend is size * 65535, formed as a shift and a subtract.
   always_comb begin
      div_size     = cmd.div_sel_y ? SZ_BITS'(sh) : SZ_BITS'(sw);
      div_dividend = (DVD_BITS'(div_size) << FB) - DVD_BITS'(div_size);
      div_divisor  = cmd.div_sel_y ? dh : dw;
   end

   nnis_div #(
      .DVD_BITS (DVD_BITS),
      .DVS_BITS (CB)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_quotient)
   );

   always_comb begin
      if (32'(acc_x_ff[SB-1:FB]) >= 32'(sw)) begin
         sc = COL_BITS'(sw - 1'b1);
      end else begin
         sc = COL_BITS'(acc_x_ff[SB-1:FB]);
      end
      if (32'(acc_y_ff[SB-1:FB]) >= 32'(sh)) begin
         sr = ROW_BITS'(sh - 1'b1);
      end else begin
         sr = ROW_BITS'(acc_y_ff[SB-1:FB]);
      end
      rd_addr     = ADDR_BITS'(sr) * ADDR_BITS'(MAX_SRC_WIDTH) + ADDR_BITS'(sc);
      wr_addr     = ADDR_BITS'(req_src_row) * ADDR_BITS'(MAX_SRC_WIDTH)
                    + ADDR_BITS'(req_src_col);
      wr_in_range = (32'(req_src_col) < 32'(MAX_SRC_WIDTH))
                    && (32'(req_src_row) < 32'(MAX_SRC_HEIGHT));
      row_end     = ((CB + 1)'(col_count_ff) + 1'b1) >= (CB + 1)'(dw);
      frame_end   = ((CB + 1)'(row_count_ff) + 1'b1) >= (CB + 1)'(dh);
   end

   always_ff @(posedge clock) begin
      if (cmd.store_write && wr_in_range) begin
         mem[wr_addr] <= req_pixel_in[PIXEL_BITS-1:0];
      end
      if (cmd.read_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff     <= nnis_pkg::SRC_SIZE_BITS'(nnis_pkg::SIZE_RESET);
         src_height_ff    <= nnis_pkg::SRC_SIZE_BITS'(nnis_pkg::SIZE_RESET);
         dst_width_ff     <= CB'(nnis_pkg::SIZE_RESET);
         dst_height_ff    <= CB'(nnis_pkg::SIZE_RESET);
         step_x_ff        <= '0;
         step_y_ff        <= '0;
         acc_x_ff         <= '0;
         acc_y_ff         <= '0;
         col_count_ff     <= '0;
         row_count_ff     <= '0;
         frame_started_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               nnis_pkg::CSR_SRC_WIDTH: begin
                  src_width_ff <= csr_write_data[nnis_pkg::SRC_SIZE_BITS-1:0];
               end
               nnis_pkg::CSR_SRC_HEIGHT: begin
                  src_height_ff <= csr_write_data[nnis_pkg::SRC_SIZE_BITS-1:0];
               end
               nnis_pkg::CSR_DST_WIDTH: begin
                  dst_width_ff <= csr_write_data;
               end
               nnis_pkg::CSR_DST_HEIGHT: begin
                  dst_height_ff <= csr_write_data;
               end
               default: begin
               end
            endcase
         end
         if (cmd.step_x_load) begin
            step_x_ff <= SB'(div_quotient);
         end
         if (cmd.step_y_load) begin
            step_y_ff <= SB'(div_quotient);
         end
         if (cmd.frame_init) begin
            acc_x_ff         <= '0;
            acc_y_ff         <= '0;
            col_count_ff     <= '0;
            row_count_ff     <= '0;
            frame_started_ff <= 1'b1;
         end else if (cmd.out_load) begin
            if (row_end) begin
               col_count_ff <= '0;
               acc_x_ff     <= '0;
               if (frame_end) begin
                  row_count_ff     <= '0;
                  acc_y_ff         <= '0;
                  frame_started_ff <= 1'b0;
               end else begin
                  row_count_ff <= row_count_ff + 1'b1;
                  acc_y_ff     <= acc_y_ff + step_y_ff;
               end
            end else begin
               col_count_ff <= col_count_ff + 1'b1;
               acc_x_ff     <= acc_x_ff + step_x_ff;
            end
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_pixel_out_ff  <= nnis_pkg::PORT_PIX_BITS'(rd_data_ff);
         rsp_out_col_ff    <= col_count_ff;
         rsp_out_row_ff    <= row_count_ff;
         rsp_frame_last_ff <= row_end && frame_end;
      end
   end

   assign status.frame_started = frame_started_ff;
   assign status.div_busy      = div_busy;
   assign status.out_blocked   = rsp_valid_ff && rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pixel_out  = rsp_pixel_out_ff;
   assign rsp_out_col    = rsp_out_col_ff;
   assign rsp_out_row    = rsp_out_row_ff;
   assign rsp_frame_last = rsp_frame_last_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/nearest_neighbor_image_scaler_core.sv -----
// Top level of the nearest-neighbor image scaler: controller plus datapath.
//
//   Channel   Direction  Handshake            Carries
//   req_*     in         req_valid/req_stall  pixel write or fetch request
//   rsp_*     out        rsp_valid/rsp_stall  scaled pixel with its position
//   csr_*     in         csr_write_en         size registers, indexes 0 to 3
//
// A write request completes on acceptance. A fetch request steps through accept, frame
// store read and load of the output register. The first fetch of a frame first runs two
// serial divisions, one per step, before the read. Reset is synchronous; the frame store
// holds garbage until written. A stalled response holds the block in its load step.
`default_nettype none

module nearest_neighbor_image_scaler_core #(
   parameter int MAX_SRC_WIDTH  = nnis_pkg::MAX_SRC_WIDTH_DEFAULT,
   parameter int MAX_SRC_HEIGHT = nnis_pkg::MAX_SRC_HEIGHT_DEFAULT,
   parameter int PIXEL_BITS     = nnis_pkg::PIXEL_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_type,
   input  wire logic [nnis_pkg::COORD_BITS-1:0]     req_src_col,
   input  wire logic [nnis_pkg::COORD_BITS-1:0]     req_src_row,
   input  wire logic [nnis_pkg::PORT_PIX_BITS-1:0]  req_pixel_in,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [nnis_pkg::PORT_PIX_BITS-1:0]       rsp_pixel_out,
   output logic [nnis_pkg::COUNT_BITS-1:0]          rsp_out_col,
   output logic [nnis_pkg::COUNT_BITS-1:0]          rsp_out_row,
   output logic                                     rsp_frame_last,
   input  wire logic                                csr_write_en,
   input  wire logic [nnis_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [nnis_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);

   nnis_pkg::cmd_type    cmd;
   nnis_pkg::status_type status;

   nnis_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .status    (status),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   nnis_datapath #(
      .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
      .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
      .PIXEL_BITS     (PIXEL_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .req_src_col    (req_src_col),
      .req_src_row    (req_src_row),
      .req_pixel_in   (req_pixel_in),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_out_col    (rsp_out_col),
      .rsp_out_row    (rsp_out_row),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

`default_nettype wire

// ----- hw/rtl/nnis_checker.sv -----
// Port-level assertions for the image scaler core and the bind that attaches them.
`default_nettype none

module nnis_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_stall,
   input wire logic                                req_type,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_stall,
   input wire logic [nnis_pkg::PORT_PIX_BITS-1:0]  rsp_pixel_out,
   input wire logic [nnis_pkg::COUNT_BITS-1:0]     rsp_out_col,
   input wire logic [nnis_pkg::COUNT_BITS-1:0]     rsp_out_row
);

   // A stalled response keeps its valid and its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_out)
         && $stable(rsp_out_col) && $stable(rsp_out_row))
      else $error("stalled response changed");

   // A write request never produces a response.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_type == nnis_pkg::REQ_WRITE |=> !$rose(rsp_valid))
      else $error("response appeared after a write request");

   // A fetch request occupies the block, so the next request must wait.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_type == nnis_pkg::REQ_FETCH |=> req_stall)
      else $error("request accepted while a fetch was in progress");

   // The response of a fetch needs the frame store read first.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_type == nnis_pkg::REQ_FETCH |=> !$rose(rsp_valid))
      else $error("fetch response came too early");

endmodule

bind nearest_neighbor_image_scaler_core nnis_checker u_nnis_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_type      (req_type),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_pixel_out (rsp_pixel_out),
   .rsp_out_col   (rsp_out_col),
   .rsp_out_row   (rsp_out_row)
);

`default_nettype wire
